/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the page free list.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* hdl/pcpfl_pkg.sv */
// Package for the per-CPU page free list: field widths, operation,
// status and register codes, reset values and the controller state type.
// No dependencies.
package pcpfl_pkg;

  localparam int ADDR_W    = 32;
  localparam int OP_W      = 2;
  localparam int CPU_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_BOUND = 2'd1;

  localparam logic [ADDR_W-1:0] LOW_BOUND_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] TOP_BOUND_RST = 32'h8800_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC,
    S_WALK
  } state_t;

endpackage

/* hdl/pcpfl_ifs.sv */
// Channel interfaces of the per-CPU page free list: request, result and
// configuration write channels with valid/ready handshakes.
// Depends on pcpfl_pkg for the field widths.
interface pcpfl_in_if;
  logic                             valid;
  logic                             ready;
  logic [pcpfl_pkg::OP_W-1:0]       op;
  logic [pcpfl_pkg::CPU_W-1:0]      cpu;
  logic [pcpfl_pkg::ADDR_W-1:0]     addr;

  modport source (output valid, output op, output cpu, output addr, input ready);
  modport sink   (input valid, input op, input cpu, input addr, output ready);
endinterface

interface pcpfl_out_if;
  logic                             valid;
  logic                             ready;
  logic [pcpfl_pkg::ADDR_W-1:0]     page_addr;
  logic [pcpfl_pkg::STATUS_W-1:0]   status;

  modport source (output valid, output page_addr, output status, input ready);
  modport sink   (input valid, input page_addr, input status, output ready);
endinterface

interface pcpfl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcpfl_pkg::CFG_IDX_W-1:0]  index;
  logic [pcpfl_pkg::ADDR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/per_cpu_page_free_list_top.sv */
// Per-CPU page free list allocator. One LIFO list of pages per CPU, threaded
// through a link memory with one entry per page slot; the list heads sit in
// flops with a valid bit each. Each request channel transfer yields exactly one
// result transfer. Allocate: the transfer cycle reads the head and starts the
// link memory read, then S_POP pops the head with the returned link once the
// output register is free. Free and the unused opcode: the transfer cycle
// registers the request, then S_EXEC checks a free's address and pushes it.
// Init walks at most PAGE_SLOTS pages, one link memory write per page. The
// link memory has no clearing pass; every entry a pop reads was written by
// the push before it. One request is worked at a time; the next request is
// taken while the result still waits in the output register. Bounds may be
// written only while idle.
module per_cpu_page_free_list_top #(
  parameter int CPUS       = 8,
  parameter int PAGE_SLOTS = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  pcpfl_in_if.sink            in_ch,
  pcpfl_out_if.source         out_ch,
  pcpfl_cfg_if.sink           cfg_ch
);

  // Page offset bits, page number width, slot and list index widths.
  localparam int PG_SHIFT = $clog2(PAGE_BYTES);
  localparam int PGN_W    = pcpfl_pkg::ADDR_W - PG_SHIFT;
  localparam int SLOT_W   = $clog2(PAGE_SLOTS);
  localparam int SCNT_W   = $clog2(PAGE_SLOTS + 1);
  localparam int LIST_W   = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int CNUM_W   = $clog2(CPUS + 1);
  localparam int MOD_W    = (pcpfl_pkg::CPU_W > CNUM_W) ? pcpfl_pkg::CPU_W : CNUM_W;
  localparam int WIDE_W   = pcpfl_pkg::ADDR_W + 1;
  localparam int MAX_CPU  = (1 << pcpfl_pkg::CPU_W) - 1;

  localparam logic [LIST_W-1:0] INIT_IDX = LIST_W'(1 % CPUS);
  localparam logic [LIST_W-1:0] LAST_IDX = LIST_W'(CPUS - 1);

  pcpfl_pkg::state_t state_r, state_nxt;

  // Bound registers.
  logic [pcpfl_pkg::ADDR_W-1:0] low_r;
  logic [pcpfl_pkg::ADDR_W-1:0] top_r;

  // Registered request.
  logic [pcpfl_pkg::OP_W-1:0]   op_r;
  logic [LIST_W-1:0]            list_r;
  logic [pcpfl_pkg::ADDR_W-1:0] addr_r;

  // List heads.
  logic [CPUS-1:0]   head_vld_r;
  logic [SLOT_W-1:0] head_slot_r [CPUS];

  // Init walk.
  logic [PGN_W:0]    pg_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [LIST_W-1:0] widx_r;

  // Output register.
  logic                           out_valid_r;
  logic [pcpfl_pkg::ADDR_W-1:0]   out_page_addr_r;
  logic [pcpfl_pkg::STATUS_W-1:0] out_status_r;

  // Control.
  logic                           in_fire;
  logic                           out_free;
  logic [LIST_W-1:0]              in_list;
  logic [LIST_W-1:0]              hd_idx;
  logic                           hd_vld;
  logic [SLOT_W-1:0]              hd_slot;
  logic                           hd_we;
  logic                           hd_wvld;
  logic [SLOT_W-1:0]              hd_wslot;
  logic                           hd_clear;
  logic                           req_ld;
  logic                           walk_start;
  logic                           walk_step;
  logic                           walk_more;
  logic                           out_ld;
  logic [pcpfl_pkg::ADDR_W-1:0]   res_addr;
  logic [pcpfl_pkg::STATUS_W-1:0] res_status;
  logic                           rd_en;
  logic                           wr_en;
  logic [SLOT_W-1:0]              wr_addr;
  logic [SLOT_W:0]                rd_data;

  // Address arithmetic.
  logic [PGN_W:0]    base_pg;
  logic [WIDE_W-1:0] pop_pg;
  logic [PGN_W:0]    free_pg;
  logic [WIDE_W-1:0] free_diff;
  logic              free_bad;
  logic [SLOT_W-1:0] free_slot;
  logic [MOD_W-1:0]  cpu_mod;

  // A request is taken only while idle.
  assign in_ch.ready = (state_r == pcpfl_pkg::S_IDLE);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Requesting CPU folded onto the available lists (cpu mod CPUS).
  always_comb begin
    cpu_mod = MOD_W'(in_ch.cpu);
    for (int i = 0; i < MAX_CPU; i++) begin
      if (cpu_mod >= MOD_W'(CPUS)) begin
        cpu_mod = cpu_mod - MOD_W'(CPUS);
      end
    end
  end
  assign in_list = LIST_W'(cpu_mod);

  // Lowest page number at or above the low bound.
  assign base_pg = {1'b0, low_r[pcpfl_pkg::ADDR_W-1:PG_SHIFT]} +
                   (PGN_W + 1)'(|low_r[PG_SHIFT-1:0]);

  // Address of the page on top of the selected list.
  assign pop_pg = WIDE_W'(base_pg) + WIDE_W'(hd_slot);

  // Free address checks: alignment, bounds, and slot range against the base.
  assign free_pg   = {1'b0, addr_r[pcpfl_pkg::ADDR_W-1:PG_SHIFT]};
  assign free_diff = WIDE_W'(free_pg - base_pg);
  assign free_slot = free_diff[SLOT_W-1:0];
  assign free_bad  = (|addr_r[PG_SHIFT-1:0]) || (addr_r < low_r) || (addr_r >= top_r) ||
                     (free_pg < base_pg) || (free_diff >= WIDE_W'(PAGE_SLOTS));

  // The walk goes on while a whole page fits below the top bound and a slot remains.
  assign walk_more = (pg_r < {1'b0, top_r[pcpfl_pkg::ADDR_W-1:PG_SHIFT]}) &&
                     (scnt_r < SCNT_W'(PAGE_SLOTS));

  // Head selection: the incoming CPU while idle, the walk list during init,
  // and the registered list otherwise.
  always_comb begin
    case (state_r)
      pcpfl_pkg::S_IDLE: hd_idx = in_list;
      pcpfl_pkg::S_WALK: hd_idx = widx_r;
      default:           hd_idx = list_r;
    endcase
  end

  assign hd_vld  = head_vld_r[hd_idx];
  assign hd_slot = head_slot_r[hd_idx];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcpfl_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == pcpfl_pkg::OP_ALLOC) begin
            state_nxt = pcpfl_pkg::S_POP;
          end else if (in_ch.op == pcpfl_pkg::OP_INIT) begin
            state_nxt = pcpfl_pkg::S_WALK;
          end else begin
            state_nxt = pcpfl_pkg::S_EXEC;
          end
        end
      end
      pcpfl_pkg::S_POP, pcpfl_pkg::S_EXEC: begin
        if (out_free) begin
          state_nxt = pcpfl_pkg::S_IDLE;
        end
      end
      pcpfl_pkg::S_WALK: begin
        if (!walk_more && out_free) begin
          state_nxt = pcpfl_pkg::S_IDLE;
        end
      end
      default: state_nxt = pcpfl_pkg::S_IDLE;
    endcase
  end

  // Datapath control. Allocate and free steps commit only when the output
  // register can take their result; init walk steps do not wait for it.
  always_comb begin
    hd_we       = 1'b0;
    hd_wvld     = 1'b0;
    hd_wslot    = hd_slot;
    hd_clear    = 1'b0;
    req_ld      = 1'b0;
    walk_start  = 1'b0;
    walk_step   = 1'b0;
    out_ld      = 1'b0;
    res_addr    = '0;
    res_status  = pcpfl_pkg::ST_OK;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = free_slot;
    case (state_r)
      pcpfl_pkg::S_IDLE: begin
        if (in_fire) begin
          req_ld = 1'b1;
          if (in_ch.op == pcpfl_pkg::OP_ALLOC) begin
            rd_en = 1'b1;
          end
          if (in_ch.op == pcpfl_pkg::OP_INIT) begin
            hd_clear   = 1'b1;
            walk_start = 1'b1;
          end
        end
      end
      pcpfl_pkg::S_POP: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (!hd_vld) begin
            res_status = pcpfl_pkg::ST_EMPTY;
          end else begin
            hd_we    = 1'b1;
            hd_wvld  = rd_data[SLOT_W];
            hd_wslot = rd_data[SLOT_W-1:0];
            res_addr = {pop_pg[PGN_W-1:0], {PG_SHIFT{1'b0}}};
          end
        end
      end
      pcpfl_pkg::S_EXEC: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (op_r == pcpfl_pkg::OP_FREE) begin
            if (free_bad) begin
              res_status = pcpfl_pkg::ST_BAD;
            end else begin
              wr_en    = 1'b1;
              hd_we    = 1'b1;
              hd_wvld  = 1'b1;
              hd_wslot = free_slot;
            end
          end
        end
      end
      pcpfl_pkg::S_WALK: begin
        if (walk_more) begin
          walk_step = 1'b1;
          wr_en     = 1'b1;
          wr_addr   = scnt_r[SLOT_W-1:0];
          hd_we     = 1'b1;
          hd_wvld   = 1'b1;
          hd_wslot  = scnt_r[SLOT_W-1:0];
        end else if (out_free) begin
          out_ld = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcpfl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes; indexes beyond the register list are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= pcpfl_pkg::LOW_BOUND_RST;
      top_r <= pcpfl_pkg::TOP_BOUND_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pcpfl_pkg::REG_LOW_BOUND: low_r <= cfg_ch.data;
        pcpfl_pkg::REG_TOP_BOUND: top_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_ld) begin
      op_r   <= in_ch.op;
      list_r <= in_list;
      addr_r <= in_ch.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
    end else if (hd_clear) begin
      head_vld_r <= '0;
    end else if (hd_we) begin
      head_vld_r[hd_idx] <= hd_wvld;
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_slot_r[hd_idx] <= hd_wslot;
    end
  end

  // Init walk counters: page number, slot, and the list that takes the page.
  always_ff @(posedge clk) begin
    if (walk_start) begin
      pg_r   <= base_pg;
      scnt_r <= '0;
      widx_r <= INIT_IDX;
    end else if (walk_step) begin
      pg_r   <= pg_r + (PGN_W + 1)'(1);
      scnt_r <= scnt_r + SCNT_W'(1);
      widx_r <= (widx_r == LAST_IDX) ? '0 : widx_r + LIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_page_addr_r <= res_addr;
      out_status_r    <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.page_addr = out_page_addr_r;
  assign out_ch.status    = out_status_r;

  // A push writes the old head, with its valid flag, as the new page's link.
  pcpfl_link_mem #(
    .DEPTH (PAGE_SLOTS),
    .WIDTH (SLOT_W + 1)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({hd_vld, hd_slot}),
    .rd_en   (rd_en),
    .rd_addr (hd_slot),
    .rd_data (rd_data)
  );

endmodule

/* hdl/pcpfl_link_mem.sv */
// Link memory of the page free list: one entry per page slot holding the
// slot below it on its list. Single write port, registered read port.
// No dependencies.
module pcpfl_link_mem #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/pcpfl_checker.sv */
// Port-level checker for the per-CPU page free list, bound to the top level.
// Depends on pcpfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcpfl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pcpfl_pkg::ADDR_W-1:0]   out_page_addr,
  input logic [pcpfl_pkg::STATUS_W-1:0] out_status
);

  // Requests taken whose result has not been transferred yet.
  logic [1:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_page_addr) && $stable(out_status))
  `CHK_IMPLY(a_no_extra_result, clk, rst_n, out_valid, pend_r != 2'd0)
  `CHK_IMPLY(a_one_in_flight, clk, rst_n, pend_r == 2'd2, !in_ready)
  `CHK_IMPLY(a_fail_no_page, clk, rst_n, out_valid && out_status != pcpfl_pkg::ST_OK, out_page_addr == '0)

endmodule

bind per_cpu_page_free_list_top pcpfl_checker u_pcpfl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_page_addr (out_ch.page_addr),
  .out_status    (out_ch.status)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the per-CPU page free list: directed and random
// requests, bound writes between phases, and a scoreboard that mirrors every list.
// Depends on pcpfl_pkg, the channel interfaces and per_cpu_page_free_list_top.
module tb_top;
  import pcpfl_pkg::*;

  // Geometry of the block under test; the mirror below uses the same numbers.
  localparam int CPUS          = 8;
  localparam int PAGE_SLOTS    = 32768;
  localparam int PAGE_BYTES    = 4096;
  localparam int SLOT_W        = $clog2(PAGE_SLOTS);
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int ITEM_TARGET   = 1350;
  // Inits in the random part only walk short windows of at most INIT_SPAN_MAX
  // pages, instead of a full pass over all slots.
  localparam int INIT_SPAN_MAX = 64;
  localparam int REPORT_MAX    = 10;

  // The opcode and register indexes that the package leaves unnamed.
  localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // One list entry: a slot number with a flag that marks it as present.
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } slot_ref_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_addr;
    logic [STATUS_W-1:0] status;
  } page_answer_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC
  } rx_pattern_t;

  // The scoreboard keeps its own copy of the lists and bounds, works out the
  // answer of every accepted request and holds it until the block answers.
  class free_list_scoreboard;
    logic [ADDR_W-1:0] low_bound;
    logic [ADDR_W-1:0] top_bound;
    slot_ref_t         head_of[CPUS];
    slot_ref_t         link_of[PAGE_SLOTS];
    page_answer_t      expected_answers[$];
    logic [ADDR_W-1:0] held_pages[$];
    int                mismatches;

    function new();
      low_bound = LOW_BOUND_RST;
      top_bound = TOP_BOUND_RST;
      foreach (head_of[i]) head_of[i] = '0;
      foreach (link_of[i]) link_of[i] = '0;
      mismatches = 0;
    endfunction

    function void set_bound(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
      case (index)
        REG_LOW_BOUND: low_bound = value;
        REG_TOP_BOUND: top_bound = value;
        default: ;
      endcase
    endfunction

    // Low bound rounded up to a whole page; may reach 2**32.
    function longint unsigned page_base();
      longint unsigned lo;
      lo = low_bound;
      return ((lo + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    // Number of pages an init would put on the lists.
    function int unsigned walk_length();
      longint unsigned base, top, n;
      base = page_base();
      top  = top_bound;
      n    = (top >= base + PAGE_BYTES) ? (top - base) / PAGE_BYTES : 0;
      return (n > PAGE_SLOTS) ? PAGE_SLOTS : int'(n);
    endfunction

    function void push_page(int unsigned list, longint unsigned slot);
      link_of[slot]      = head_of[list];
      head_of[list].vld  = 1'b1;
      head_of[list].slot = slot[SLOT_W-1:0];
    endfunction

    function void rebuild_lists();
      longint unsigned p, top, slot, k;
      foreach (head_of[i]) head_of[i] = '0;
      p    = page_base();
      top  = top_bound;
      slot = 0;
      k    = 0;
      while (p + PAGE_BYTES <= top && slot < PAGE_SLOTS) begin
        k++;
        push_page(int'(k % CPUS), slot);
        p += PAGE_BYTES;
        slot++;
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [CPU_W-1:0] cpu,
                               logic [ADDR_W-1:0] addr);
      page_answer_t    ans;
      int unsigned     list;
      longint unsigned base, a, slot;
      slot_ref_t       top_ref;
      logic            bad;
      ans.page_addr = '0;
      ans.status    = ST_OK;
      list = int'(cpu) % CPUS;
      base = page_base();
      a    = addr;
      case (op)
        OP_ALLOC: begin
          top_ref = head_of[list];
          if (!top_ref.vld) begin
            ans.status = ST_EMPTY;
          end else begin
            head_of[list] = link_of[top_ref.slot];
            slot          = top_ref.slot;
            ans.page_addr = ADDR_W'(base + slot * PAGE_BYTES);
            held_pages.push_back(ans.page_addr);
            if (held_pages.size() > 256) void'(held_pages.pop_front());
          end
        end
        OP_FREE: begin
          bad = (a % PAGE_BYTES) != 0 || addr < low_bound || addr >= top_bound || a < base;
          slot = 0;
          if (!bad) begin
            slot = (a - base) / PAGE_BYTES;
            bad  = slot >= PAGE_SLOTS;
          end
          if (bad) ans.status = ST_BAD;
          else push_page(list, slot);
        end
        OP_INIT: rebuild_lists();
        default: ;
      endcase
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic [ADDR_W-1:0] page_addr, logic [STATUS_W-1:0] status);
      page_answer_t want;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with no request outstanding: page_addr %h status %0d",
                   $time, page_addr, status);
        return;
      end
      want = expected_answers.pop_front();
      if (want.page_addr !== page_addr || want.status !== status) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: page_addr exp %h got %h, status exp %0d got %0d",
                   $time, want.page_addr, page_addr, want.status, status);
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    // Hands back a page that an earlier allocate returned.
    function logic [ADDR_W-1:0] take_held();
      int                idx;
      logic [ADDR_W-1:0] a;
      idx = $urandom_range(0, held_pages.size() - 1);
      a   = held_pages[idx];
      held_pages.delete(idx);
      return a;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pcpfl_in_if  in_ch();
  pcpfl_out_if out_ch();
  pcpfl_cfg_if cfg_ch();

  per_cpu_page_free_list_top #(
    .CPUS       (CPUS),
    .PAGE_SLOTS (PAGE_SLOTS),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  free_list_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both channels are sampled at the rising edge, before any flop of the
  // block or any driver of the testbench has updated. A result is checked
  // before the request of the same edge is noted, since a result always
  // belongs to a request accepted at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.page_addr, out_ch.status);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.op, in_ch.cpu, in_ch.addr);
    end
  end

  // The receiver switches at random between stall patterns: always ready,
  // mostly ready, rarely ready, and a periodic stall. Stretches of the first
  // give runs without stalls.
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          phase_cnt;
    pattern      = RX_ALWAYS;
    pattern_left = 0;
    phase_cnt    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pattern_left == 0) begin
        pattern      = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
      end else begin
        pattern_left--;
      end
      phase_cnt++;
      case (pattern)
        RX_ALWAYS:   out_ch.ready <= 1'b1;
        RX_MOSTLY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_RARELY:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ch.ready <= (phase_cnt % 8 != 0);
      endcase
    end
  end

  // Presents one request and returns at the edge where it transfers. Valid is
  // left high, so that the next request can follow at once; the sender works
  // in bursts of random length and lowers valid only for the gap between two.
  task automatic issue(input logic [OP_W-1:0] op, input logic [CPU_W-1:0] cpu,
                       input logic [ADDR_W-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        // Idle cycles carry junk on the payload lines.
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_W'($urandom);
        in_ch.cpu   <= CPU_W'($urandom);
        in_ch.addr  <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.cpu   <= cpu;
    in_ch.addr  <= addr;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Stops the sender and waits until every outstanding answer has arrived.
  // Valid is low from the first edge on, so the loop sees every transfer.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; only called with the block idle. The extra edge keeps
  // a following write from raising valid in the step that lowers it.
  task automatic write_bound(input logic [CFG_IDX_W-1:0] index,
                             input logic [ADDR_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    sb.set_bound(index, value);
    @(posedge clk);
  endtask

  // Mostly a page that an allocate handed out, else an aligned page from the base up to the walk length plus eight.
  function automatic logic [ADDR_W-1:0] wellformed_page();
    longint unsigned spot;
    if (sb.held_pages.size() != 0 && $urandom_range(0, 3) != 0) return sb.take_held();
    spot = sb.page_base() + longint'($urandom_range(0, sb.walk_length() + 8)) * PAGE_BYTES;
    return spot[ADDR_W-1:0];
  endfunction

  // Addresses that a free must refuse, or nearly so.
  function automatic logic [ADDR_W-1:0] stray_address();
    longint unsigned base;
    base = sb.page_base();
    case ($urandom_range(0, 4))
      0: return ADDR_W'(base) | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
      1: return sb.low_bound - ADDR_W'($urandom_range(1, 3) * PAGE_BYTES);
      2: return (sb.top_bound >> PAGE_SHIFT) << PAGE_SHIFT;
      3: return ADDR_W'(base + longint'(PAGE_SLOTS + $urandom_range(0, 3)) * PAGE_BYTES);
      default: return $urandom;
    endcase
  endfunction

  // Directed part: the field extremes, every opcode and each corner case.
  task automatic directed_checks();
    // Reset bounds: a window of exactly one full set of slots.
    issue(OP_ALLOC, 3'd0, 32'h0000_0000);   // empty list after reset
    issue(OP_FREE, 3'd2, 32'h8000_0800);    // misaligned
    issue(OP_FREE, 3'd7, 32'h8000_0000);    // first slot
    issue(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
    issue(OP_FREE, 3'd3, 32'h8800_0000);    // exactly at the top bound
    issue(OP_FREE, 3'd3, 32'h87FF_F000);    // last slot
    issue(OP_ALLOC, 3'd3, 32'h0000_0000);
    issue(OP_UNUSED, 3'd5, 32'hFFFF_FFFF);  // unused opcode does nothing
    issue(OP_FREE, 3'd4, 32'h0000_0000);    // below the low bound
    issue(OP_INIT, 3'd6, 32'h0000_0000);    // full walk of every slot
    issue(OP_ALLOC, 3'd1, 32'h0000_0000);
    issue(OP_ALLOC, 3'd0, 32'h0000_0000);
    // Double free: the same page lands on the list twice.
    issue(OP_FREE, 3'd0, 32'h8000_0000);
    issue(OP_FREE, 3'd0, 32'h8000_0000);
    issue(OP_ALLOC, 3'd0, 32'h0000_0000);
    issue(OP_ALLOC, 3'd0, 32'h0000_0000);
    drain();

    // Unaligned low bound and a window wider than the slot count.
    write_bound(REG_LOW_BOUND, 32'h0000_0001);
    write_bound(REG_TOP_BOUND, 32'hFFFF_FFFF);
    issue(OP_FREE, 3'd6, 32'h0800_1000);    // first slot past the slot count
    issue(OP_FREE, 3'd6, 32'h0800_0000);    // last slot
    issue(OP_INIT, 3'd1, 32'h0000_0000);    // walk stops at the slot count
    issue(OP_ALLOC, 3'd7, 32'h0000_0000);
    drain();

    // Low bound that rounds past the address space; the spare indexes too.
    write_bound(REG_LOW_BOUND, 32'hFFFF_FFFF);
    write_bound(REG_TOP_BOUND, 32'h0000_0000);
    write_bound(REG_SPARE_A, 32'h5A5A_5A5A);
    write_bound(REG_SPARE_B, 32'hA5A5_A5A5);
    issue(OP_INIT, 3'd0, 32'h0000_0000);    // repeated init empties all lists
    issue(OP_ALLOC, 3'd2, 32'h0000_0000);
    issue(OP_FREE, 3'd2, 32'hFFFF_F000);
    drain();

    // Eight pages, then the base moves under them: the allocated address
    // follows the new base and wraps at 32 bits.
    write_bound(REG_LOW_BOUND, 32'h0000_1000);
    write_bound(REG_TOP_BOUND, 32'h0000_9000);
    issue(OP_INIT, 3'd0, 32'h0000_0000);
    drain();
    write_bound(REG_LOW_BOUND, 32'hFFFF_F000);
    issue(OP_ALLOC, 3'd0, 32'h0000_0000);
    issue(OP_ALLOC, 3'd1, 32'h0000_0000);
    drain();
    write_bound(REG_TOP_BOUND, 32'hFFFF_FFFF);
    issue(OP_FREE, 3'd5, 32'hFFFF_F000);    // highest page of the address space
    issue(OP_ALLOC, 3'd5, 32'h0000_0000);
  endtask

  // One random phase: new bounds written while idle, then a stream that is
  // mostly allocates and frees of pages the lists really hold, with some
  // refused frees, unused opcodes and short re-inits mixed in.
  task automatic random_phase();
    int                kind, count, pick, span;
    logic [ADDR_W-1:0] lo, hi;
    longint unsigned   hi_wide;
    kind = $urandom_range(0, 9);
    lo   = $urandom;
    if ($urandom_range(0, 2) != 0) lo[PAGE_SHIFT-1:0] = '0;
    span = $urandom_range(0, 40);
    if (kind == 7) begin
      // Wide window: frees may land past the slot count.
      lo   = $urandom_range(0, 32'h4000_0000);
      span = PAGE_SLOTS + $urandom_range(1, 2048);
    end
    hi_wide = lo;
    hi_wide = hi_wide + longint'(span) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
    hi = (hi_wide > 64'hFFFF_FFFF) ? '1 : hi_wide[ADDR_W-1:0];
    if (kind == 8) begin
      lo = $urandom;
      hi = $urandom;
    end

    drain();
    if (kind == 9) begin
      // Only one register moves; the other keeps its value.
      if ($urandom_range(0, 1) != 0) write_bound(REG_LOW_BOUND, lo);
      else write_bound(REG_TOP_BOUND, hi);
    end else if ($urandom_range(0, 1) != 0) begin
      write_bound(REG_LOW_BOUND, lo);
      write_bound(REG_TOP_BOUND, hi);
    end else begin
      write_bound(REG_TOP_BOUND, hi);
      write_bound(REG_LOW_BOUND, lo);
    end

    if (sb.walk_length() <= INIT_SPAN_MAX && $urandom_range(0, 9) != 0)
      issue(OP_INIT, CPU_W'($urandom), $urandom);
    count = $urandom_range(30, 110);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        issue(OP_ALLOC, CPU_W'($urandom), $urandom);
      else if (pick < 80)
        issue(OP_FREE, CPU_W'($urandom), wellformed_page());
      else if (pick < 92)
        issue(OP_FREE, CPU_W'($urandom), stray_address());
      else if (pick < 96)
        issue(OP_UNUSED, CPU_W'($urandom), $urandom);
      else if (sb.walk_length() <= INIT_SPAN_MAX)
        issue(OP_INIT, CPU_W'($urandom), $urandom);
      else
        issue(OP_ALLOC, CPU_W'($urandom), $urandom);
    end
  endtask

  // Main sequence. Every input is known from time zero; reset is held low
  // and released synchronously, once.
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_ALLOC;
    in_ch.cpu    <= '0;
    in_ch.addr   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_LOW_BOUND;
    cfg_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_checks();
    while (items_sent < ITEM_TARGET) random_phase();

    // Let the last answers arrive, then wait on for anything stray.
    drain();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: two full-slot walks plus all the random traffic stay far below
  // this, even with the receiver at its slowest.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
